@@ src/srgb_box_downsample_2x_top_macros.svh @@
// Assertion macros shared by the downsampler RTL.
`ifndef SRGB_BOX_DOWNSAMPLE_2X_TOP_MACROS_SVH
`define SRGB_BOX_DOWNSAMPLE_2X_TOP_MACROS_SVH

// Same-cycle implication, checked on clk outside reset.
`define SBD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk outside reset.
`define SBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sbd2x_pkg.sv @@
// Package with sizes, register indexes and colour tables of the downsampler.
`timescale 1ns / 1ps
package sbd2x_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int DIM_W      = 13;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int LIN_W      = 21;
  localparam int THR_W      = 22;
  localparam int SUM_W      = 23;
  localparam int STAGES     = 8;

  localparam logic REG_SRC_WIDTH  = 1'b0;
  localparam logic REG_SRC_HEIGHT = 1'b1;

  typedef logic [LIN_W-1:0] lin_tab_t [256];
  typedef logic [THR_W-1:0] thr_tab_t [255];

  function automatic real srgb_to_lin(real s);
    real l;
    if (s <= 0.04045) begin
      l = s / 12.92;
    end else begin
      l = ((s + 0.055) / 1.055) ** 2.4;
    end
    return l;
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t t;
    real      x;
    int       v;
    for (int i = 0; i < 256; i++) begin
      x = 1048576.0 * srgb_to_lin(real'(i) / 255.0);
      v = int'(x);
      t[i] = LIN_W'(v);
    end
    return t;
  endfunction

  function automatic thr_tab_t build_thr();
    thr_tab_t t;
    real      x;
    int       v;
    for (int k = 0; k < 255; k++) begin
      x = 4194304.0 * srgb_to_lin((real'(k) + 0.5) / 255.0);
      v = int'(x);
      if (real'(v) < x) begin
        v = v + 1;
      end else if (real'(v - 1) >= x) begin
        v = v - 1;
      end
      t[k] = THR_W'(v);
    end
    return t;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam thr_tab_t THR_TAB = build_thr();

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(maxv)) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/srgb_box_downsample_2x_top.sv @@
// 2x2 box downsampler in linear light for an RGBA8 stream with sRGB re-encoding.
// A quad passes the input register, the sum stage and the eight search stages before out_tvalid rises.
// Throughput: one source pixel per cycle, set by the single-port line store and the
// eight-stage threshold search; the whole pipeline holds only while an output word waits.
// Reset clears counters, left pixel, stage valids and sets both sizes to 1; the line store
// keeps its contents and needs no clearing pass.
`timescale 1ns / 1ps
`include "srgb_box_downsample_2x_top_macros.svh"
module srgb_box_downsample_2x_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,   // in_red, in_green, in_blue, in_alpha
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,  // out_red, out_green, out_blue, out_alpha
  output logic                       out_tlast,  // frame_end
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [sbd2x_pkg::DIM_W-1:0] cfg_data
);
  import sbd2x_pkg::*;

  logic [DIM_W-1:0] width_r, height_r, col_r, row_r, col_nxt, row_nxt;
  logic [DIM_W-1:0] w_eff, h_eff, col0, row0;
  logic [DIM_W:0]   row_t, col_inc, row_inc;
  logic             w1, h1, emit, last_px, in_acc, en;
  logic [31:0]      left_r;

  logic [31:0]      store_mem [MAX_WIDTH];
  logic [31:0]      rd_r, prev_rd_r;
  logic [ADDR_W-1:0] addr;

  logic             a_vld_r;
  logic [31:0]      a_cur_r, a_bl_r;
  logic             a_w1_r, a_h1_r, a_last_r;

  logic [31:0]      q_tl, q_tr;
  logic [SUM_W-1:0] sum_b [3];
  logic [9:0]       asum_b;

  logic             vld_r  [STAGES+1];
  logic [SUM_W-1:0] sum_r  [STAGES+1][3];
  logic [7:0]       code_r [STAGES+1][3];
  logic [7:0]       code_nxt [STAGES+1][3];
  logic [7:0]       alpha_r [STAGES+1];
  logic             last_r [STAGES+1];

  assign cfg_ready = 1'b1;
  assign en        = !vld_r[STAGES] || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  always_comb begin
    w_eff   = clamp_dim(width_r, MAX_WIDTH);
    h_eff   = clamp_dim(height_r, MAX_HEIGHT);
    w1      = (w_eff == DIM_W'(1));
    h1      = (h_eff == DIM_W'(1));
    col0    = (col_r >= w_eff) ? '0 : col_r;
    row_t   = (col_r >= w_eff) ? ({1'b0, row_r} + (DIM_W+1)'(1)) : {1'b0, row_r};
    row0    = (row_t >= {1'b0, h_eff}) ? '0 : row_t[DIM_W-1:0];
    col_inc = {1'b0, col0} + (DIM_W+1)'(1);
    row_inc = {1'b0, row0} + (DIM_W+1)'(1);
    if (col_inc >= {1'b0, w_eff}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_nxt = col_inc[DIM_W-1:0];
      row_nxt = row0;
    end
    emit    = (w1 || col0[0]) && (h1 || row0[0]);
    last_px = (w1 || ((col0 >> 1) == ((w_eff >> 1) - DIM_W'(1)))) &&
              (h1 || ((row0 >> 1) == ((h_eff >> 1) - DIM_W'(1))));
    addr    = col0[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!row0[0]) begin
        store_mem[addr] <= in_tdata;
      end
      rd_r      <= store_mem[addr];
      prev_rd_r <= rd_r;
    end
  end

  always_comb begin
    if (a_h1_r) begin
      q_tl = a_bl_r;
      q_tr = a_cur_r;
    end else if (a_w1_r) begin
      q_tl = rd_r;
      q_tr = rd_r;
    end else begin
      q_tl = prev_rd_r;
      q_tr = rd_r;
    end
    for (int c = 0; c < 3; c++) begin
      sum_b[c] = SUM_W'(LIN_TAB[q_tl[8*c +: 8]]) + SUM_W'(LIN_TAB[q_tr[8*c +: 8]]) +
                 SUM_W'(LIN_TAB[a_bl_r[8*c +: 8]]) + SUM_W'(LIN_TAB[a_cur_r[8*c +: 8]]);
    end
    asum_b = 10'(q_tl[31:24]) + 10'(q_tr[31:24]) + 10'(a_bl_r[31:24]) +
             10'(a_cur_r[31:24]) + 10'd2;
  end

  always_comb begin
    for (int p = 0; p <= STAGES; p++) begin
      for (int c = 0; c < 3; c++) begin
        code_nxt[p][c] = code_r[p][c];
      end
    end
    for (int p = 1; p <= STAGES; p++) begin
      for (int c = 0; c < 3; c++) begin
        logic [7:0] cand;
        cand = code_r[p-1][c] | (8'd1 << (STAGES - p));
        if (sum_r[p-1][c] >= SUM_W'(THR_TAB[cand - 8'd1])) begin
          code_nxt[p][c] = cand;
        end else begin
          code_nxt[p][c] = code_r[p-1][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
      a_vld_r  <= 1'b0;
      for (int p = 0; p <= STAGES; p++) begin
        vld_r[p] <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_SRC_WIDTH:  width_r  <= cfg_data;
          REG_SRC_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        left_r <= in_tdata;
      end
      if (en) begin
        a_vld_r  <= in_acc && emit;
        vld_r[0] <= a_vld_r;
        for (int p = 1; p <= STAGES; p++) begin
          vld_r[p] <= vld_r[p-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_cur_r  <= in_tdata;
      a_bl_r   <= w1 ? in_tdata : left_r;
      a_w1_r   <= w1;
      a_h1_r   <= h1;
      a_last_r <= last_px;
      for (int c = 0; c < 3; c++) begin
        sum_r[0][c]  <= sum_b[c];
        code_r[0][c] <= '0;
      end
      alpha_r[0] <= asum_b[9:2];
      last_r[0]  <= a_last_r;
      for (int p = 1; p <= STAGES; p++) begin
        for (int c = 0; c < 3; c++) begin
          sum_r[p][c]  <= sum_r[p-1][c];
          code_r[p][c] <= code_nxt[p][c];
        end
        alpha_r[p] <= alpha_r[p-1];
        last_r[p]  <= last_r[p-1];
      end
    end
  end

  assign out_tvalid = vld_r[STAGES];
  assign out_tdata  = {alpha_r[STAGES], code_r[STAGES][2], code_r[STAGES][1],
                       code_r[STAGES][0]};
  assign out_tlast  = last_r[STAGES];

  `SBD_ASSERT_NOW(a_stall_blocks_input, out_tvalid && !out_tready, !in_tready, "input taken while output stalled")
  `SBD_ASSERT_NOW(a_counters_in_range, 1'b1, (col_r < DIM_W'(MAX_WIDTH)) && (row_r < DIM_W'(MAX_HEIGHT)), "position counter out of range")
  `SBD_ASSERT_NEXT(a_quad_enters_search, a_vld_r && en, vld_r[0], "quad lost before sum stage")

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the sRGB-correct 2x2 box downsampler.
`timescale 1ns / 1ps
module testbench;
  import sbd2x_pkg::*;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct {
    pixel_t px;
    logic   last;
  } mip_pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_SRC_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  int error_count = 0;
  bit hold_output = 1'b0;
  bit stim_done = 1'b0;

  always #6 clk = ~clk;

  srgb_box_downsample_2x_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Exact sRGB decode: compares L(p/q) against num/2^sh with big integers.
  function automatic int lin_cmp(int unsigned p, int unsigned q, longint unsigned num,
                                 int unsigned sh);
    logic [415:0] lhs, rhs;
    longint unsigned a, b, l, r;
    if (longint'(p) * 100000 <= longint'(q) * 4045) begin
      l = (longint'(p) * 100) << sh;
      r = num * 1292 * q;
      return l > r ? 1 : (l < r ? -1 : 0);
    end
    a = 1000 * p + 55 * q;
    b = 1055 * q;
    lhs = 1;
    rhs = 1;
    for (int i = 0; i < 12; i++) begin
      lhs = lhs * a;
      rhs = rhs * b;
    end
    lhs = lhs << (5 * sh);
    for (int i = 0; i < 5; i++) rhs = rhs * num;
    return lhs > rhs ? 1 : (lhs < rhs ? -1 : 0);
  endfunction

  function automatic int unsigned search_level(int unsigned p, int unsigned q, bit decode);
    int unsigned lo, hi, mid;
    bit ok;
    lo = 0;
    hi = decode ? (1 << 20) : (1 << 22);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      ok = decode ? (lin_cmp(p, q, 2 * mid + 1, 21) >= 0) : (lin_cmp(p, q, mid, 22) > 0);
      if (ok) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  class mip_scoreboard;
    int unsigned decode_lut[256];
    int unsigned encode_thr[255];
    int unsigned width, height, col, row;
    pixel_t line_buf[MAX_WIDTH];
    pixel_t left_px;
    mip_pixel_t pending[$];

    function new();
      for (int i = 0; i < 256; i++) decode_lut[i] = search_level(i, 255, 1'b1);
      for (int k = 0; k < 255; k++) encode_thr[k] = search_level(2 * k + 1, 510, 1'b0);
      width = 1;
      height = 1;
      col = 0;
      row = 0;
      left_px = '0;
    endfunction

    function void set_size(logic idx, int unsigned v);
      if (v < 1) v = 1;
      if (idx == REG_SRC_WIDTH) width = v > MAX_WIDTH ? MAX_WIDTH : v;
      else height = v > MAX_HEIGHT ? MAX_HEIGHT : v;
    endfunction

    function logic [7:0] reencode(pixel_t q[4], int sh);
      int unsigned sum, code;
      sum = 0;
      code = 0;
      for (int i = 0; i < 4; i++) sum += decode_lut[(q[i] >> sh) & 8'hff];
      for (int k = 0; k < 255; k++) if (sum >= encode_thr[k]) code++;
      return code[7:0];
    endfunction

    function void note_pixel(pixel_t cur);
      pixel_t q[4];
      mip_pixel_t m;
      int unsigned dw, dh, ox, oy, asum;
      if (col >= width) begin
        col = 0;
        row++;
      end
      if (row >= height) row = 0;
      if ((width == 1 || col[0]) && (height == 1 || row[0])) begin
        dw = width == 1 ? 1 : width / 2;
        dh = height == 1 ? 1 : height / 2;
        ox = width == 1 ? 0 : col / 2;
        oy = height == 1 ? 0 : row / 2;
        q[3] = cur;
        q[2] = width == 1 ? cur : left_px;
        if (height == 1) begin
          q[0] = q[2];
          q[1] = q[3];
        end else if (width == 1) begin
          q[0] = line_buf[col];
          q[1] = line_buf[col];
        end else begin
          q[0] = line_buf[col - 1];
          q[1] = line_buf[col];
        end
        m.px.red = reencode(q, 0);
        m.px.green = reencode(q, 8);
        m.px.blue = reencode(q, 16);
        asum = 2;
        for (int i = 0; i < 4; i++) asum += q[i].alpha;
        m.px.alpha = asum[9:2];
        m.last = (ox == dw - 1) && (oy == dh - 1);
        pending.insert(pending.size(), m);
      end
      if (!row[0]) line_buf[col] = cur;
      left_px = cur;
      col++;
      if (col >= width) begin
        col = 0;
        row++;
        if (row >= height) row = 0;
      end
    endfunction

    task check_pixel(pixel_t got, logic last);
      mip_pixel_t m;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", got, 0);
        return;
      end
      m = pending.pop_front();
      if (got.red !== m.px.red) report_mismatch("red", got.red, m.px.red);
      if (got.green !== m.px.green) report_mismatch("green", got.green, m.px.green);
      if (got.blue !== m.px.blue) report_mismatch("blue", got.blue, m.px.blue);
      if (got.alpha !== m.px.alpha) report_mismatch("alpha", got.alpha, m.px.alpha);
      if (last !== m.last) report_mismatch("frame_end", last, m.last);
    endtask
  endclass

  mip_scoreboard sb;

  task automatic write_reg(logic idx, int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(v);
    do @(posedge clk); while (!cfg_ready);
    sb.set_size(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pixel(pixel_t p, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= p;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(p);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic pixel_t random_pixel();
    return pixel_t'($urandom);
  endfunction

  task automatic send_level(int w, int h, bit no_gap);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    for (int i = 0; i < w * h; i++) send_pixel(random_pixel(), no_gap);
    drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
  end

  initial begin
    int wait_cycles;
    @(negedge clk);
    forever begin
      if (hold_output) begin
        out_tready <= 1'b0;
        @(negedge clk);
      end else if (stim_done || $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b1;
        @(negedge clk);
      end else begin
        wait_cycles = $urandom_range(0, 9);
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
        out_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  initial begin
    pixel_t edge_px[4];
    int items, w, h;
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes: black, white, mixed alpha in a 2x2 level.
    edge_px[0] = 32'h00000000;
    edge_px[1] = 32'hffffffff;
    edge_px[2] = 32'h00ff00ff;
    edge_px[3] = 32'hff00ff00;
    write_reg(REG_SRC_WIDTH, 2);
    write_reg(REG_SRC_HEIGHT, 2);
    foreach (edge_px[i]) send_pixel(edge_px[i], 1'b0);
    for (int i = 0; i < 4; i++) send_pixel(32'hffffffff, 1'b0);
    drain();
    // One-wide, one-high, odd sizes and out-of-range register values.
    send_level(1, 3, 1'b0);
    send_level(3, 1, 1'b0);
    send_level(1, 1, 1'b0);
    send_level(3, 3, 1'b0);
    write_reg(REG_SRC_WIDTH, 0);
    write_reg(REG_SRC_HEIGHT, 0);
    send_pixel(32'h80402010, 1'b0);
    drain();
    // Start of an over-wide row, then a 1x1 size brings the position back to the origin.
    write_reg(REG_SRC_WIDTH, 13'h1fff);
    write_reg(REG_SRC_HEIGHT, 1);
    for (int i = 0; i < 96; i++) send_pixel(random_pixel(), 1'b1);
    drain();
    write_reg(REG_SRC_WIDTH, 1);
    send_pixel(random_pixel(), 1'b0);
    drain();

    // Back-pressure: hold the receiver while the sender keeps offering.
    fork
      begin
        hold_output = 1'b1;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end
      send_level(8, 16, 1'b1);
    join

    items = 0;
    while (items < 480) begin
      w = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 9);
      h = $urandom_range(1, 8);
      send_level(w, h, $urandom_range(0, 3) == 0);
      items += w * h;
    end
    write_reg(REG_SRC_WIDTH, 1);
    write_reg(REG_SRC_HEIGHT, 1);

    stim_done = 1'b1;
    drain();
    if (error_count == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule

@@ srgb_box_downsample_2x_top.f @@
+incdir+src
src/sbd2x_pkg.sv
src/srgb_box_downsample_2x_top.sv
tb/sv/testbench.sv
